### hw/rtl/mcptg_pkg.sv
// Package for the multi-channel pulse train generator.
// Holds sizes, command and status codes, item structs and the slot record type.
// No dependencies.
`default_nettype none

package mcptg_pkg;

  localparam int CHANNELS    = 8;
  localparam int TIME_BITS   = 32;
  localparam int COUNT_BITS  = 16;
  localparam int SLOT_BITS   = $clog2(CHANNELS);
  localparam int MAX_RESULTS = 8;
  localparam int FIRE_BITS   = $clog2(MAX_RESULTS + 1);
  localparam int PIN_W       = 8;
  localparam int OUT_SLOT_W  = 3;

  localparam logic [PIN_W-1:0] FREE_PIN = 8'd255;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_START   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic {
    KIND_RESPONSE = 1'b0,
    KIND_DRIVE    = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  pin;
    logic        polarity;
    logic [31:0] delay_ticks;
    logic [31:0] active_ticks;
    logic [31:0] cycle_ticks;
    logic [15:0] pulse_count;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] status;
    logic [2:0] slot;
    logic [7:0] drive_pin;
    logic       level;
    logic       last;
  } out_item_t;

  // Timing state of one slot, kept in the slot RAM
  typedef struct packed {
    logic                  active_level;
    logic                  phase;
    logic [COUNT_BITS-1:0] pulses_left;
    logic [TIME_BITS-1:0]  width_ticks;
    logic [TIME_BITS-1:0]  period_ticks;
    logic [TIME_BITS-1:0]  wait_ticks;
  } slot_rec_t;

endpackage

`default_nettype wire

### hw/rtl/mcptg_slot_ram.sv
// Slot record RAM: one write port, one read port with registered read data.
// Depends on mcptg_pkg for the record type and slot count.
`default_nettype none

module mcptg_slot_ram
  import mcptg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [SLOT_BITS-1:0] wr_addr,
  input  wire slot_rec_t            wr_data,
  input  wire logic [SLOT_BITS-1:0] rd_addr,
  output slot_rec_t                 rd_data
);

  slot_rec_t mem [CHANNELS];
  slot_rec_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hw/rtl/multi_channel_pulse_train_generator.sv
// Multi-channel pulse train generator; depends on mcptg_pkg and mcptg_slot_ram.
// Start, release and unknown commands: busy stays low, the response strobes next cycle.
// A tick holds busy through the scan, drain and flush states: the slot RAM is read one
// slot per cycle, each record is updated and written back the cycle after its read.
// Drive events strobe at most one per cycle; the last one in the first cycle busy is low.
// Synchronous reset frees every slot at once through per-slot valid bits.
`default_nettype none

module multi_channel_pulse_train_generator
  import mcptg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  // Registers
  state_t                 state_r,     state_nxt;
  logic [SLOT_BITS-1:0]   rd_idx_r,    rd_idx_nxt;
  logic                   proc_v_r,    proc_v_nxt;
  logic [SLOT_BITS-1:0]   proc_idx_r,  proc_idx_nxt;
  logic [FIRE_BITS-1:0]   fired_cnt_r, fired_cnt_nxt;
  logic                   pend_v_r,    pend_v_nxt;
  out_item_t              pend_r,      pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r,  out_item_nxt;
  logic [CHANNELS-1:0]    valid_r,     valid_nxt;
  logic [PIN_W-1:0]       pin_r [CHANNELS];
  logic [PIN_W-1:0]       pin_nxt [CHANNELS];

  // RAM ports
  logic                   wr_en;
  logic [SLOT_BITS-1:0]   wr_addr;
  slot_rec_t              wr_data;
  logic [SLOT_BITS-1:0]   rd_addr;
  slot_rec_t              rd_data;

  // Slot lookup
  logic                   hit_found;
  logic [SLOT_BITS-1:0]   hit_idx;
  logic                   free_found;
  logic [SLOT_BITS-1:0]   free_idx;
  logic                   slot_found;
  logic [SLOT_BITS-1:0]   slot_idx;

  // Tick update of the slot under processing
  logic                   live;
  logic                   fire;
  logic [TIME_BITS-1:0]   wait_dec;
  logic [TIME_BITS:0]     gap_diff;
  logic [TIME_BITS-1:0]   gap;
  slot_rec_t              upd_rec;
  out_item_t              drive_item;

  logic                   accept;

  mcptg_slot_ram u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign rd_addr = rd_idx_r;

  // Find lowest slot bound to the pin, else lowest free slot
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = CHANNELS - 1; s >= 0; s--) begin
      if (valid_r[s]) begin
        if (pin_r[s] == in_item.pin) begin
          hit_found = 1'b1;
          hit_idx   = SLOT_BITS'(s);
        end
      end else begin
        free_found = 1'b1;
        free_idx   = SLOT_BITS'(s);
      end
    end
    slot_found = hit_found || free_found;
    slot_idx   = hit_found ? hit_idx : free_idx;
  end

  // Count down the slot read last cycle and decide whether it fires
  always_comb begin
    live     = proc_v_r && valid_r[proc_idx_r] && (rd_data.pulses_left != '0);
    wait_dec = rd_data.wait_ticks - TIME_BITS'(rd_data.wait_ticks != '0);
    fire     = live && (wait_dec == '0) && (fired_cnt_r < FIRE_BITS'(MAX_RESULTS));
    gap_diff = {1'b0, rd_data.period_ticks} - {1'b0, rd_data.width_ticks};
    gap      = gap_diff[TIME_BITS] ? '0 : gap_diff[TIME_BITS-1:0];

    upd_rec            = rd_data;
    upd_rec.wait_ticks = wait_dec;
    drive_item           = '0;
    drive_item.kind      = KIND_DRIVE;
    drive_item.status    = STATUS_OK;
    drive_item.slot      = OUT_SLOT_W'(proc_idx_r);
    drive_item.drive_pin = pin_r[proc_idx_r];
    drive_item.last      = 1'b0;
    if (!rd_data.phase) begin
      drive_item.level = rd_data.active_level;
    end else begin
      drive_item.level = ~rd_data.active_level;
    end
    if (fire) begin
      if (!rd_data.phase) begin
        upd_rec.wait_ticks = rd_data.width_ticks;
        upd_rec.phase      = 1'b1;
      end else begin
        upd_rec.wait_ticks  = gap;
        upd_rec.phase       = 1'b0;
        upd_rec.pulses_left = rd_data.pulses_left - COUNT_BITS'(1);
      end
    end
  end

  // Next state, RAM write and result selection
  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    proc_v_nxt    = 1'b0;
    proc_idx_nxt  = rd_idx_r;
    fired_cnt_nxt = fired_cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    valid_nxt     = valid_r;
    pin_nxt       = pin_r;

    // Write back the updated slot; the scan never revisits an entry
    wr_en   = live;
    wr_addr = proc_idx_r;
    wr_data = upd_rec;

    // Hold the newest event; release the older one with last low
    if (fire) begin
      fired_cnt_nxt = fired_cnt_r + FIRE_BITS'(1);
      pend_v_nxt    = 1'b1;
      pend_nxt      = drive_item;
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = pend_r;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_item_nxt           = '0;
          out_item_nxt.kind      = KIND_RESPONSE;
          out_item_nxt.drive_pin = in_item.pin;
          out_item_nxt.last      = 1'b1;
          unique case (cmd_e'(in_item.command))
            CMD_TICK: begin
              state_nxt     = ST_SCAN;
              rd_idx_nxt    = '0;
              fired_cnt_nxt = '0;
              pend_v_nxt    = 1'b0;
            end
            CMD_START, CMD_RELEASE: begin
              out_valid_nxt = 1'b1;
              if (!slot_found) begin
                out_item_nxt.status = STATUS_INVALID;
              end else begin
                out_item_nxt.status = STATUS_OK;
                out_item_nxt.slot   = OUT_SLOT_W'(slot_idx);
                if (cmd_e'(in_item.command) == CMD_START) begin
                  // A start on the free pin code leaves the slot free
                  valid_nxt[slot_idx]  = (in_item.pin != FREE_PIN);
                  pin_nxt[slot_idx]    = in_item.pin;
                  wr_en                = 1'b1;
                  wr_addr              = slot_idx;
                  wr_data.active_level = in_item.polarity;
                  wr_data.phase        = 1'b0;
                  wr_data.pulses_left  = COUNT_BITS'(in_item.pulse_count);
                  wr_data.width_ticks  = TIME_BITS'(in_item.active_ticks);
                  wr_data.period_ticks = TIME_BITS'(in_item.cycle_ticks);
                  wr_data.wait_ticks   = TIME_BITS'(in_item.delay_ticks);
                end else begin
                  valid_nxt[slot_idx] = 1'b0;
                end
              end
            end
            CMD_UNKNOWN: begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = STATUS_UNKNOWN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        proc_v_nxt   = 1'b1;
        proc_idx_nxt = rd_idx_r;
        if (rd_idx_r == SLOT_BITS'(CHANNELS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + SLOT_BITS'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        // Emit the held event as the final one of this tick
        if (pend_v_r) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt      = pend_r;
          out_item_nxt.last = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      proc_v_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      rd_idx_r    <= '0;
      fired_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      proc_v_r    <= proc_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
      fired_cnt_r <= fired_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
    pin_r      <= pin_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
